### sv/cpu_interrupt_and_sleep_control_defines.svh
// -----------------------------------------------------------------------------
// cpu_interrupt_and_sleep_control_defines.svh
// Assertion macros used by the interrupt and sleep control port checker.
// -----------------------------------------------------------------------------
`ifndef CPU_INTERRUPT_AND_SLEEP_CONTROL_DEFINES_SVH
`define CPU_INTERRUPT_AND_SLEEP_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define CISC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted during reset.
`define CISC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/cisc_pkg.sv
// -----------------------------------------------------------------------------
// cisc_pkg
// Types and constants of the CPU interrupt and sleep control block.
// -----------------------------------------------------------------------------
package cisc_pkg;

	localparam int ACT_W  = 3;
	localparam int JOY_W  = 8;
	localparam int IRQ_W  = 5;
	localparam int ADDR_W = 16;
	localparam int OUT_W  = 2;
	localparam int CYC_W  = 3;
	localparam int IDX_W  = 3;

	// joypad byte: active-low key lines and select lines
	localparam logic [JOY_W-1:0] JOY_KEY_MASK = 8'h0F;
	localparam logic [JOY_W-1:0] JOY_SEL_MASK = 8'h30;

	localparam logic [CYC_W-1:0] CYC_NONE = 3'd0;
	localparam logic [CYC_W-1:0] CYC_WAKE = 3'd4;
	localparam logic [CYC_W-1:0] CYC_IRQ  = 3'd5;

	// push frame is two bytes
	localparam logic [ADDR_W-1:0] PUSH_BYTES = 16'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_STEP      = 3'd0,
		ACT_EI        = 3'd1,
		ACT_DI        = 3'd2,
		ACT_EI_DELAY  = 3'd3,
		ACT_HALT      = 3'd4,
		ACT_STOP      = 3'd5
	} action_t;

	typedef enum logic [OUT_W-1:0] {
		OUTC_NONE  = 2'd0,
		OUTC_WAKE  = 2'd1,
		OUTC_TAKEN = 2'd2,
		OUTC_FETCH = 2'd3
	} outcome_t;

endpackage

### sv/cpu_interrupt_and_sleep_control.sv
// -----------------------------------------------------------------------------
// cpu_interrupt_and_sleep_control
// Interrupt dispatch, halt and stop handling for a small 8-bit CPU core.
// -----------------------------------------------------------------------------
//
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------
// input    in_valid / in_ready  action, joypad_lines, irq_flags, irq_enables,
//                               prog_counter, stack_ptr
// output   out_valid/out_ready  outcome, cycle_count, clear_index, next_pc,
//                               next_sp, pushed_word
//
// One item per clock sustained while out_ready stays high; each item passes
// the input register _s1, then decision logic into the result register _q.
// Flag state (master enable, delayed enable, halted, stopped) updates as an
// item moves from _s1 into the result register, so items see it in order.
// A stalled result holds _s1, and in_ready drops only when both are full.
// arst_n clears valids and the four flags; payload registers are not reset.
//
module cpu_interrupt_and_sleep_control
	import cisc_pkg::*;
#(
	parameter int VECTOR_BASE = 64,
	parameter int NUM_SOURCES = 5
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [JOY_W-1:0]  joypad_lines,
	input  logic [IRQ_W-1:0]  irq_flags,
	input  logic [IRQ_W-1:0]  irq_enables,
	input  logic [ADDR_W-1:0] prog_counter,
	input  logic [ADDR_W-1:0] stack_ptr,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  outcome,
	output logic [CYC_W-1:0]  cycle_count,
	output logic [IDX_W-1:0]  clear_index,
	output logic [ADDR_W-1:0] next_pc,
	output logic [ADDR_W-1:0] next_sp,
	output logic [ADDR_W-1:0] pushed_word
);

	// only the low NUM_SOURCES request lines take part
	localparam int SRC_USED = (NUM_SOURCES < IRQ_W) ? NUM_SOURCES : IRQ_W;
	localparam logic [IRQ_W-1:0] SRC_MASK = IRQ_W'((1 << SRC_USED) - 1);
	localparam logic [ADDR_W-1:0] VEC_BASE = ADDR_W'(VECTOR_BASE);

	// input stage
	logic              valid_s1;
	logic [ACT_W-1:0]  action_s1;
	logic [JOY_W-1:0]  joy_s1;
	logic [IRQ_W-1:0]  flags_s1;
	logic [IRQ_W-1:0]  enables_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic [ADDR_W-1:0] sp_s1;

	// CPU flags
	logic master_enable_q, enable_pending_q, is_halted_q, is_stopped_q;
	logic master_enable_d, enable_pending_d, is_halted_d, is_stopped_d;

	// result register
	logic              out_valid_q;
	outcome_t          outcome_q;
	logic [CYC_W-1:0]  cycles_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] npc_q;
	logic [ADDR_W-1:0] nsp_q;
	logic [ADDR_W-1:0] pushed_q;

	outcome_t          outcome_d;
	logic [CYC_W-1:0]  cycles_d;
	logic [IDX_W-1:0]  idx_d;
	logic [ADDR_W-1:0] npc_d;
	logic [ADDR_W-1:0] nsp_d;
	logic [ADDR_W-1:0] pushed_d;

	logic              advance;
	logic [IRQ_W-1:0]  pending;
	logic [IDX_W-1:0]  pend_idx;
	logic              wake_req;
	logic              woke;
	logic              taken;
	logic [JOY_W-1:0]  joy_low;

	// result register frees when empty or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1  <= action;
			joy_s1     <= joypad_lines;
			flags_s1   <= irq_flags;
			enables_s1 <= irq_enables;
			pc_s1      <= prog_counter;
			sp_s1      <= stack_ptr;
		end
	end

	// lowest-numbered pending and enabled source wins
	assign pending = flags_s1 & enables_s1 & SRC_MASK;

	always_comb begin
		pend_idx = '0;
		for (int i = IRQ_W - 1; i >= 0; i--) begin
			if (pending[i]) begin
				pend_idx = IDX_W'(i);
			end
		end
	end

	// keys and selects are active low: need one of each pulled down
	assign joy_low  = ~joy_s1;
	assign wake_req = ((joy_low & JOY_KEY_MASK) != '0) && ((joy_low & JOY_SEL_MASK) != '0);

	always_comb begin
		master_enable_d  = master_enable_q;
		enable_pending_d = enable_pending_q;
		is_halted_d      = is_halted_q;
		is_stopped_d     = is_stopped_q;
		woke             = 1'b0;
		taken            = 1'b0;
		outcome_d        = OUTC_NONE;
		cycles_d         = CYC_NONE;
		idx_d            = '0;
		npc_d            = pc_s1;
		nsp_d            = sp_s1;
		pushed_d         = '0;

		unique case (action_s1)
			ACT_STEP: begin
				// stop masks interrupts entirely
				if (is_stopped_q) begin
					if (wake_req) begin
						is_stopped_d = 1'b0;
						woke         = 1'b1;
					end
				end else if ((pending != '0) && master_enable_q) begin
					is_halted_d = 1'b0;
					taken       = 1'b1;
				end

				// still asleep (or woke from stop into halt): nothing to report
				if (!is_stopped_d && !is_halted_d) begin
					priority if (taken) begin
						outcome_d = OUTC_TAKEN;
						cycles_d  = CYC_IRQ;
						idx_d     = pend_idx;
						pushed_d  = pc_s1;
						nsp_d     = sp_s1 - PUSH_BYTES;
						npc_d     = VEC_BASE + {{(ADDR_W-IDX_W-3){1'b0}}, pend_idx, 3'b000};
					end else if (woke) begin
						outcome_d = OUTC_WAKE;
						cycles_d  = CYC_WAKE;
					end else begin
						// delayed enable lands one step late
						if (enable_pending_q) begin
							master_enable_d  = 1'b1;
							enable_pending_d = 1'b0;
						end
						outcome_d = OUTC_FETCH;
					end
				end
			end
			ACT_EI:       master_enable_d  = 1'b1;
			ACT_DI:       master_enable_d  = 1'b0;
			ACT_EI_DELAY: enable_pending_d = 1'b1;
			ACT_HALT:     is_halted_d      = 1'b1;
			ACT_STOP:     is_stopped_d     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_enable_q  <= 1'b0;
			enable_pending_q <= 1'b0;
			is_halted_q      <= 1'b0;
			is_stopped_q     <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (advance) begin
				master_enable_q  <= master_enable_d;
				enable_pending_q <= enable_pending_d;
				is_halted_q      <= is_halted_d;
				is_stopped_q     <= is_stopped_d;
				out_valid_q      <= 1'b1;
			end else if (out_ready) begin
				out_valid_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= outcome_d;
			cycles_q  <= cycles_d;
			idx_q     <= idx_d;
			npc_q     <= npc_d;
			nsp_q     <= nsp_d;
			pushed_q  <= pushed_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign outcome     = outcome_q;
	assign cycle_count = cycles_q;
	assign clear_index = idx_q;
	assign next_pc     = npc_q;
	assign next_sp     = nsp_q;
	assign pushed_word = pushed_q;

endmodule

### sv/cisc_checker.sv
// -----------------------------------------------------------------------------
// cisc_checker
// Port-level checks on the interrupt and sleep control block.
// -----------------------------------------------------------------------------
`include "cpu_interrupt_and_sleep_control_defines.svh"

module cisc_checker
	import cisc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [OUT_W-1:0]  outcome,
	input logic [CYC_W-1:0]  cycle_count,
	input logic [IDX_W-1:0]  clear_index,
	input logic [ADDR_W-1:0] next_pc,
	input logic [ADDR_W-1:0] next_sp,
	input logic [ADDR_W-1:0] pushed_word
);

	logic [OUT_W+CYC_W+IDX_W+3*ADDR_W-1:0] res_item;
	logic out_stall;
	logic is_taken, is_wake, is_quiet;
	logic idx_ok, no_side;

	assign res_item  = {outcome, cycle_count, clear_index, next_pc, next_sp, pushed_word};
	assign out_stall = out_valid && !out_ready;
	assign is_taken  = out_valid && (outcome == OUTC_TAKEN);
	assign is_wake   = out_valid && (outcome == OUTC_WAKE);
	assign is_quiet  = out_valid && ((outcome == OUTC_NONE) || (outcome == OUTC_FETCH));
	assign idx_ok    = clear_index < IDX_W'(IRQ_W);
	assign no_side   = (clear_index == '0) && (pushed_word == '0);

	// a stalled result item stays put
	`CISC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_item), "stalled result item changed")

	// an empty result register never holds the input off
	`CISC_ASSERT_NOW(a_ready_free, in_valid && !out_valid, in_ready, "input blocked with no result waiting")

	// dispatch always reports the CYC_IRQ cost and a valid source
	`CISC_ASSERT_NOW(a_irq_cycles, is_taken, (cycle_count == CYC_IRQ) && idx_ok, "interrupt item malformed")

	// stop wake: CYC_WAKE cost, no push, no source
	`CISC_ASSERT_NOW(a_wake_shape, is_wake, (cycle_count == CYC_WAKE) && no_side, "wake item malformed")

	// no dispatch: CYC_NONE cost, nothing pushed
	`CISC_ASSERT_NOW(a_idle_shape, is_quiet, (cycle_count == CYC_NONE) && no_side, "idle item malformed")

endmodule

bind cpu_interrupt_and_sleep_control cisc_checker u_cisc_checker (.*);

### tb/irq_decision_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// irq_decision_checker
// Watches both channels of the interrupt and sleep control block, predicts
// the decision for every accepted item and compares it with the result.
// -----------------------------------------------------------------------------
module irq_decision_checker
	import cisc_pkg::*;
#(
	parameter int VECTOR_BASE = 64,
	parameter int NUM_SOURCES = 5
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [JOY_W-1:0]  joypad_lines,
	input  logic [IRQ_W-1:0]  irq_flags,
	input  logic [IRQ_W-1:0]  irq_enables,
	input  logic [ADDR_W-1:0] prog_counter,
	input  logic [ADDR_W-1:0] stack_ptr,

	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [OUT_W-1:0]  outcome,
	input  logic [CYC_W-1:0]  cycle_count,
	input  logic [IDX_W-1:0]  clear_index,
	input  logic [ADDR_W-1:0] next_pc,
	input  logic [ADDR_W-1:0] next_sp,
	input  logic [ADDR_W-1:0] pushed_word,

	output int                mismatches,
	output int                waiting,
	output int                n_checked,
	output int                n_taken,
	output int                n_woken,
	output int                n_fetched
);

	localparam logic [IRQ_W-1:0] SRC_MASK = IRQ_W'((1 << NUM_SOURCES) - 1);

	typedef struct {
		outcome_t          outc;
		logic [CYC_W-1:0]  cyc;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] pc;
		logic [ADDR_W-1:0] sp;
		logic [ADDR_W-1:0] pushed;
	} decision_t;

	decision_t due_decisions[$];
	decision_t want;

	// predictor's copy of the flag state
	logic irq_master_en, ei_pending, cpu_halted, cpu_stopped;

	function automatic decision_t predict_decision(
		input logic [ACT_W-1:0]  act,
		input logic [JOY_W-1:0]  joy,
		input logic [IRQ_W-1:0]  flg,
		input logic [IRQ_W-1:0]  ena,
		input logic [ADDR_W-1:0] pc,
		input logic [ADDR_W-1:0] sp
	);
		decision_t d;
		logic [IRQ_W-1:0] live;
		logic [JOY_W-1:0] lines;
		logic taken, woke;
		d.outc   = OUTC_NONE;
		d.cyc    = CYC_NONE;
		d.idx    = '0;
		d.pc     = pc;
		d.sp     = sp;
		d.pushed = '0;
		taken    = 1'b0;
		woke     = 1'b0;
		case (act)
			ACT_STEP: begin
				if (cpu_stopped) begin
					lines = ~joy;
					if ((lines & JOY_KEY_MASK) != '0 && (lines & JOY_SEL_MASK) != '0) begin
						cpu_stopped = 1'b0;
						woke = 1'b1;
					end
				end else begin
					live = flg & ena & SRC_MASK;
					if (live != '0 && irq_master_en) begin
						for (int i = IRQ_W - 1; i >= 0; i--)
							if (live[i]) d.idx = IDX_W'(i);
						cpu_halted = 1'b0;
						taken = 1'b1;
					end
				end
				if (cpu_stopped || cpu_halted) begin
					d.idx = '0;
				end else if (taken) begin
					d.outc   = OUTC_TAKEN;
					d.cyc    = CYC_IRQ;
					d.pushed = pc;
					d.sp     = sp - PUSH_BYTES;
					d.pc     = ADDR_W'(VECTOR_BASE + 8 * d.idx);
				end else if (woke) begin
					d.outc = OUTC_WAKE;
					d.cyc  = CYC_WAKE;
				end else begin
					if (ei_pending) begin
						irq_master_en = 1'b1;
						ei_pending = 1'b0;
					end
					d.outc = OUTC_FETCH;
				end
			end
			ACT_EI:       irq_master_en = 1'b1;
			ACT_DI:       irq_master_en = 1'b0;
			ACT_EI_DELAY: ei_pending = 1'b1;
			ACT_HALT:     cpu_halted = 1'b1;
			ACT_STOP:     cpu_stopped = 1'b1;
			default: ;
		endcase
		return d;
	endfunction

	task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
			input logic [ADDR_W-1:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$realtime, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_decisions.delete();
			irq_master_en = 1'b0;
			ei_pending    = 1'b0;
			cpu_halted    = 1'b0;
			cpu_stopped   = 1'b0;
			mismatches    = 0;
			waiting       = 0;
			n_checked     = 0;
			n_taken       = 0;
			n_woken       = 0;
			n_fetched     = 0;
		end else begin
			// results first: an item accepted at this edge must still pass the input
			// and result registers, so it cannot be the one leaving
			if (out_valid && out_ready) begin
				if (due_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no item outstanding, outcome %0d",
							$realtime, outcome);
				end else begin
					want = due_decisions.pop_front();
					n_checked++;
					check_field("outcome",     ADDR_W'(want.outc), ADDR_W'(outcome));
					check_field("cycle_count", ADDR_W'(want.cyc),  ADDR_W'(cycle_count));
					check_field("clear_index", ADDR_W'(want.idx),  ADDR_W'(clear_index));
					check_field("next_pc",     want.pc,            next_pc);
					check_field("next_sp",     want.sp,            next_sp);
					check_field("pushed_word", want.pushed,        pushed_word);
					case (want.outc)
						OUTC_TAKEN: n_taken++;
						OUTC_WAKE:  n_woken++;
						OUTC_FETCH: n_fetched++;
						default: ;
					endcase
				end
			end
			if (in_valid && in_ready)
				due_decisions.push_back(predict_decision(action, joypad_lines, irq_flags,
					irq_enables, prog_counter, stack_ptr));
			waiting = due_decisions.size();
		end
	end

endmodule

### tb/cpu_interrupt_and_sleep_control_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cpu_interrupt_and_sleep_control_tb
// Drives directed and sequence-shaped random items through the interrupt and
// sleep control block under bursty input and a stalling receiver; a checker
// beside the block predicts and compares every result.
// -----------------------------------------------------------------------------
module cpu_interrupt_and_sleep_control_tb
	import cisc_pkg::*;
;

	localparam int VECTOR_BASE = 64;
	localparam int NUM_SOURCES = 5;
	localparam int ITEM_TARGET = 1850;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;		// margin after the final drain

	// action codes with no meaning; the block changes no flag and reports OUTC_NONE
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ACT_W-1:0]  action = '0;
	logic [JOY_W-1:0]  joypad_lines = '0;
	logic [IRQ_W-1:0]  irq_flags = '0;
	logic [IRQ_W-1:0]  irq_enables = '0;
	logic [ADDR_W-1:0] prog_counter = '0;
	logic [ADDR_W-1:0] stack_ptr = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [OUT_W-1:0]  outcome;
	logic [CYC_W-1:0]  cycle_count;
	logic [IDX_W-1:0]  clear_index;
	logic [ADDR_W-1:0] next_pc;
	logic [ADDR_W-1:0] next_sp;
	logic [ADDR_W-1:0] pushed_word;

	int mismatches, waiting, n_checked, n_taken, n_woken, n_fetched;
	int cycle_no = 0;
	int items_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_run = 0;
	bit paused = 1'b0;

	always #5 clk = ~clk;

	cpu_interrupt_and_sleep_control #(
		.VECTOR_BASE (VECTOR_BASE),
		.NUM_SOURCES (NUM_SOURCES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.joypad_lines  (joypad_lines),
		.irq_flags     (irq_flags),
		.irq_enables   (irq_enables),
		.prog_counter  (prog_counter),
		.stack_ptr     (stack_ptr),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.outcome       (outcome),
		.cycle_count   (cycle_count),
		.clear_index   (clear_index),
		.next_pc       (next_pc),
		.next_sp       (next_sp),
		.pushed_word   (pushed_word)
	);

	irq_decision_checker #(
		.VECTOR_BASE (VECTOR_BASE),
		.NUM_SOURCES (NUM_SOURCES)
	) u_decision_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.joypad_lines  (joypad_lines),
		.irq_flags     (irq_flags),
		.irq_enables   (irq_enables),
		.prog_counter  (prog_counter),
		.stack_ptr     (stack_ptr),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.outcome       (outcome),
		.cycle_count   (cycle_count),
		.clear_index   (clear_index),
		.next_pc       (next_pc),
		.next_sp       (next_sp),
		.pushed_word   (pushed_word),
		.mismatches    (mismatches),
		.waiting       (waiting),
		.n_checked     (n_checked),
		.n_taken       (n_taken),
		.n_woken       (n_woken),
		.n_fetched     (n_fetched)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == CYCLE_LIMIT) begin
			$display("[cpu_interrupt_and_sleep_control] ERROR");
			$finish;
		end
	end

	// receiver: each stretch picks a mode - always ready, coin toss, mostly
	// stalled, or a fixed one-in-three gap
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_run  <= $urandom_range(8, 60);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycle_no % 3 != 0);
		endcase
	end

	// one item on the input channel; opens a new burst, after a random gap,
	// whenever the current one is used up
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [JOY_W-1:0] joy,
			input logic [IRQ_W-1:0] flg, input logic [IRQ_W-1:0] ena,
			input logic [ADDR_W-1:0] pc, input logic [ADDR_W-1:0] sp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		action        <= act;
		joypad_lines  <= joy;
		irq_flags     <= flg;
		irq_enables   <= ena;
		prog_counter  <= pc;
		stack_ptr     <= sp;
		do @(posedge clk); while (!in_ready);
		// unused action codes change no flag, so they do not count
		if (act <= ACT_STOP)
			items_sent++;
	endtask

	task automatic send_rand(input logic [ACT_W-1:0] act);
		send_item(act, JOY_W'($urandom), IRQ_W'($urandom), IRQ_W'($urandom),
			ADDR_W'($urandom), ADDR_W'($urandom));
	endtask

	// step carrying one guaranteed pending and enabled source
	task automatic send_irq_step();
		logic [IRQ_W-1:0] hit;
		hit = IRQ_W'(1 << $urandom_range(0, IRQ_W - 1));
		send_item(ACT_STEP, JOY_W'($urandom), IRQ_W'($urandom) | hit,
			IRQ_W'($urandom) | hit, ADDR_W'($urandom), ADDR_W'($urandom));
	endtask

	// step with one key line and one select line pulled low
	task automatic send_wake_step();
		logic [JOY_W-1:0] joy;
		joy = JOY_W'($urandom);
		joy[$urandom_range(0, 3)] = 1'b0;
		joy[$urandom_range(4, 5)] = 1'b0;
		send_item(ACT_STEP, joy, IRQ_W'($urandom), IRQ_W'($urandom),
			ADDR_W'($urandom), ADDR_W'($urandom));
	endtask

	// step whose joypad cannot wake: all keys up or no line selected
	task automatic send_quiet_joy_step();
		logic [JOY_W-1:0] joy;
		joy = JOY_W'($urandom) | ($urandom_range(0, 1) ? JOY_KEY_MASK : JOY_SEL_MASK);
		send_item(ACT_STEP, joy, IRQ_W'($urandom), IRQ_W'($urandom),
			ADDR_W'($urandom), ADDR_W'($urandom));
	endtask

	// hold the sender off until every outstanding result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	// well-formed sequences that reach past the first states
	task automatic run_sequence();
		case ($urandom_range(0, 5))
			0: begin	// delayed enable lands on the next fetch
				send_rand(ACT_EI_DELAY);
				if ($urandom_range(0, 1)) send_rand(ACT_DI);
				send_rand(ACT_STEP);
				send_irq_step();
			end
			1: begin	// halt, a few idle steps, leave through an interrupt
				send_rand(ACT_EI);
				send_rand(ACT_HALT);
				repeat ($urandom_range(0, 3)) send_rand(ACT_STEP);
				send_irq_step();
			end
			2: begin	// stop, presses that do not count, then a real wake
				send_rand(ACT_STOP);
				repeat ($urandom_range(0, 3)) send_quiet_joy_step();
				send_wake_step();
				send_rand(ACT_STEP);
			end
			3: begin	// masked off, then opened up again
				send_rand(ACT_DI);
				send_irq_step();
				send_rand(ACT_EI);
				send_irq_step();
			end
			4: begin	// wake from stop while still halted
				send_rand(ACT_HALT);
				send_rand(ACT_STOP);
				send_wake_step();
				send_rand(ACT_STEP);
				send_rand(ACT_EI);
				send_irq_step();
			end
			default: begin
				repeat ($urandom_range(1, 6)) send_rand(ACT_STEP);
			end
		endcase
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh state, vectors at both ends, stack wrap
		send_item(ACT_STEP, 8'h00, 5'h1F, 5'h1F, 16'h0000, 16'h0000);	// master off: fetch
		send_item(ACT_EI,   8'hFF, 5'h00, 5'h00, 16'hFFFF, 16'hFFFF);
		send_item(ACT_STEP, 8'hFF, 5'h1F, 5'h1F, 16'hFFFF, 16'h0000);	// source 0, sp wraps
		send_item(ACT_STEP, 8'hFF, 5'h10, 5'h1F, 16'h1234, 16'h0001);	// highest source
		send_item(ACT_STEP, 8'hC0, 5'h1F, 5'h00, 16'hFFFF, 16'hFFFF);	// nothing enabled
		send_item(ACT_DI,   8'h00, 5'h1F, 5'h1F, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'h00, 5'h1F, 5'h1F, 16'hA5A5, 16'h5A5A);	// masked: fetch
		// delayed enable, and disable leaving the mark in place
		send_item(ACT_EI_DELAY, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'h00, 5'h1F, 5'h1F, 16'h0100, 16'hFFFE);	// fetch, arms master
		send_item(ACT_STEP, 8'h00, 5'h04, 5'h0C, 16'h0150, 16'hDFFF);	// source 2
		send_item(ACT_DI,   8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_EI_DELAY, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_DI,   8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'h00, 5'h08, 5'h08, 16'h0200, 16'h8000);	// fetch, arms master
		send_item(ACT_STEP, 8'h00, 5'h08, 5'h08, 16'h0201, 16'h8000);	// source 3
		// halt: idle step, then an interrupt ends it
		send_item(ACT_HALT, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'h00, 5'h00, 5'h1F, 16'h0300, 16'h7000);	// no work
		send_item(ACT_STEP, 8'h00, 5'h01, 5'h01, 16'h0301, 16'h7000);	// taken, halt clears
		// stop: press without select, select without press, then a wake
		send_item(ACT_STOP, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'hF0, 5'h1F, 5'h1F, 16'h0400, 16'h6000);
		send_item(ACT_STEP, 8'h0F, 5'h1F, 5'h1F, 16'h0401, 16'h6000);
		send_item(ACT_STEP, 8'h00, 5'h1F, 5'h1F, 16'h0402, 16'h6000);	// wake, irqs ignored
		// wake while halted gives nothing, halt stays
		send_item(ACT_HALT, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STOP, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);
		send_item(ACT_STEP, 8'hEE, 5'h00, 5'h00, 16'h0500, 16'h5000);
		send_item(ACT_STEP, 8'h00, 5'h02, 5'h02, 16'h0501, 16'h5000);	// source 1 ends halt
		// unused action codes
		send_item(ACT_SPARE_A, 8'hFF, 5'h1F, 5'h1F, 16'hFFFF, 16'hFFFF);
		send_item(ACT_SPARE_B, 8'h00, 5'h00, 5'h00, 16'h0000, 16'h0000);

		// random: mostly sequences with random content, the rest loose noise
		while (items_sent < ITEM_TARGET) begin
			if (!paused && items_sent >= ITEM_TARGET / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 7)
				run_sequence();
			else
				send_rand(ACT_W'($urandom_range(0, 7)));
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d results: %0d interrupts taken, %0d stop wakes, %0d fetches,",
			n_checked, n_taken, n_woken, n_fetched);
		$display("the rest idle or flag updates, with bursty input and receiver stalls.");
		if (mismatches == 0 && waiting == 0)
			$display("[cpu_interrupt_and_sleep_control] OK");
		else
			$display("[cpu_interrupt_and_sleep_control] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/cisc_pkg.sv
sv/cpu_interrupt_and_sleep_control.sv
sv/cisc_checker.sv
tb/irq_decision_checker.sv
tb/cpu_interrupt_and_sleep_control_tb.sv
